[rtl/core/bgi_pkg.sv]
// Shared types, constants and helpers of the bilinear grid interpolator.
// No dependencies; imported by bgi_blend, bgi_seq and the top level.
`default_nettype none
package bgi_pkg;

  localparam int X_MAX      = 64;
  localparam int Y_MAX      = 64;
  localparam int X_AW       = $clog2(X_MAX);
  localparam int Y_AW       = $clog2(Y_MAX);
  localparam int AX_AW      = (X_AW > Y_AW) ? X_AW : Y_AW;
  localparam int AXN_W      = AX_AW + 1;
  localparam int GRID_DEPTH = X_MAX * Y_MAX;
  localparam int G_AW       = $clog2(GRID_DEPTH);

  localparam int CNT_W  = 7;
  localparam int VAL_W  = 32;
  localparam int SLOT_W = 12;
  localparam int NUM_W  = VAL_W + 1;
  localparam int D_W    = 64;
  localparam int MAG_W  = 63;
  localparam int PROD_W = MAG_W + NUM_W;
  localparam int CNT_BW = $clog2(PROD_W);
  localparam int MID_SH = 61;

  localparam logic signed [D_W-1:0] MID_LIM = 64'sh2000_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD_X    = 2'd0,
    CMD_LOAD_Y    = 2'd1,
    CMD_LOAD_GRID = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NEG        = 2'd1,
    ST_ZERO_WIDTH = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_S0, S_S1, S_S2, S_S3, S_E0, S_E1, S_E2, S_CHK,
    S_G0, S_G1, S_G2, S_G3, S_G4,
    S_B1, S_W1, S_B2, S_W2, S_B3, S_W3, S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    B_IDLE, B_MUL, B_DIV, B_FIN
  } blend_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [D_W-1:0]   base;
    logic signed [D_W-1:0]   d;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] den;
  } blend_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [D_W-1:0] value;
  } blend_rsp_t;

  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    status_t                 status;
  } result_t;

  function automatic logic [AXN_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
                                                 input int unsigned mx);
    int unsigned c;
    c = 32'(cnt);
    if (c < 2) c = 2;
    if (c > mx) c = mx;
    return AXN_W'(c);
  endfunction

endpackage
`default_nettype wire

[rtl/core/bgi_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none
module bgi_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/bgi_blend.sv]
// Serial blend unit: base + trunc(d * num / den), shift-add multiply then
// restoring division, one bit per cycle. Depends on bgi_pkg.
`default_nettype none
module bgi_blend (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bgi_pkg::blend_req_t req,
  output bgi_pkg::blend_rsp_t     rsp
);
  import bgi_pkg::*;

  blend_state_t          state, state_next;
  logic [PROD_W-1:0]     mcand;
  logic [PROD_W-1:0]     acc;
  logic [NUM_W-1:0]      mplier;
  logic [NUM_W-1:0]      w;
  logic [NUM_W-1:0]      rem;
  logic [CNT_BW-1:0]     cnt;
  logic                  neg;
  logic signed [D_W-1:0] base;
  logic signed [D_W-1:0] value;
  logic                  done;

  logic [D_W-1:0]        d_mag;
  logic [NUM_W-1:0]      num_mag;
  logic [NUM_W-1:0]      den_mag;
  logic [NUM_W:0]        trial;
  logic                  qbit;
  logic                  ovf;
  logic signed [D_W-1:0] qmag;
  logic signed [D_W-1:0] qs;
  logic signed [D_W-1:0] sum;
  logic signed [D_W-1:0] clamped;

  always_comb begin
    d_mag   = req.d[D_W-1] ? D_W'(-req.d) : D_W'(req.d);
    num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    den_mag = req.den[NUM_W-1] ? NUM_W'(-req.den) : NUM_W'(req.den);
    trial   = {rem, acc[PROD_W-1]};
    qbit    = (trial >= {1'b0, w});
    ovf     = (|acc[PROD_W-1:MID_SH+1]) || (acc[MID_SH] && (|acc[MID_SH-1:0]));
    qmag    = ovf ? MID_LIM : D_W'(acc[MID_SH:0]);
    qs      = neg ? -qmag : qmag;
    sum     = base + qs;
    if (sum > MID_LIM) begin
      clamped = MID_LIM;
    end else if (sum < -MID_LIM) begin
      clamped = -MID_LIM;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == B_FIN);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (req.start) state_next = B_MUL;
      B_MUL:   if (cnt == CNT_BW'(NUM_W - 1)) state_next = B_DIV;
      B_DIV:   if (cnt == CNT_BW'(PROD_W - 1)) state_next = B_FIN;
      B_FIN:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (req.start) begin
          mcand  <= PROD_W'(d_mag[MAG_W-1:0]);
          mplier <= num_mag;
          w      <= den_mag;
          neg    <= req.d[D_W-1] ^ req.num[NUM_W-1] ^ req.den[NUM_W-1];
          base   <= req.base;
          acc    <= '0;
          cnt    <= '0;
        end
      end
      B_MUL: begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        rem    <= '0;
        cnt    <= (cnt == CNT_BW'(NUM_W - 1)) ? '0 : cnt + 1'b1;
      end
      B_DIV: begin
        rem <= qbit ? NUM_W'(trial - {1'b0, w}) : trial[NUM_W-1:0];
        acc <= {acc[PROD_W-2:0], qbit};
        cnt <= cnt + 1'b1;
      end
      B_FIN: begin
        value <= clamped;
      end
      default: begin
      end
    endcase
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule
`default_nettype wire

[rtl/core/bgi_seq.sv]
// Query sequencer: axis and grid memories, linear cell search, corner reads
// and the three blend steps. Depends on bgi_pkg, bgi_ram and bgi_blend.
`default_nettype none
module bgi_seq (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire bgi_pkg::cmd_t                  command,
  input  wire logic [bgi_pkg::SLOT_W-1:0]     slot,
  input  wire logic [bgi_pkg::VAL_W-1:0]      load_value,
  input  wire logic signed [bgi_pkg::VAL_W-1:0] query_x,
  input  wire logic signed [bgi_pkg::VAL_W-1:0] query_y,
  input  wire logic [bgi_pkg::CNT_W-1:0]      x_count,
  input  wire logic [bgi_pkg::CNT_W-1:0]      y_count,
  output bgi_pkg::result_t                    res,
  input  wire logic                           res_ready
);
  import bgi_pkg::*;

  seq_state_t state, state_next;

  logic                    accept;
  logic                    x_we, y_we, g_we;
  logic [AX_AW-1:0]        rd_addr;
  logic [G_AW-1:0]         g_raddr;
  logic [VAL_W-1:0]        x_rd, y_rd, g_rd;
  logic signed [VAL_W-1:0] ax_rd;
  logic signed [VAL_W-1:0] qv;
  logic [AXN_W-1:0]        n_cur;

  logic                    ax_sel;
  logic [AXN_W-1:0]        nx, ny;
  logic [AX_AW-1:0]        k, cell_idx, i, j;
  logic signed [VAL_W-1:0] qx, qy, lo_bp, lo_v, x0, x1, y0, y1;
  logic signed [VAL_W-1:0] c1, c2, c3, c4;
  logic [G_AW-1:0]         gbase;
  logic signed [D_W-1:0]   a_val, b_val;
  logic signed [VAL_W-1:0] out_val;
  status_t                 out_st;

  logic signed [NUM_W-1:0] wx, wy;
  logic [G_AW-1:0]         ny_g, im1_g, jm1_g;
  logic signed [VAL_W-1:0] v_sat;
  blend_req_t              breq;
  blend_rsp_t              brsp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign x_we = accept && (command == CMD_LOAD_X)    && (32'(slot) < 32'(X_MAX));
  assign y_we = accept && (command == CMD_LOAD_Y)    && (32'(slot) < 32'(Y_MAX));
  assign g_we = accept && (command == CMD_LOAD_GRID) && (32'(slot) < 32'(GRID_DEPTH));

  bgi_ram #(.DEPTH(X_MAX), .WIDTH(VAL_W)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(slot[X_AW-1:0]), .wdata(load_value),
    .raddr(rd_addr[X_AW-1:0]), .rdata(x_rd)
  );

  bgi_ram #(.DEPTH(Y_MAX), .WIDTH(VAL_W)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(slot[Y_AW-1:0]), .wdata(load_value),
    .raddr(rd_addr[Y_AW-1:0]), .rdata(y_rd)
  );

  bgi_ram #(.DEPTH(GRID_DEPTH), .WIDTH(VAL_W)) u_grid_ram (
    .clk(clk), .we(g_we), .waddr(slot[G_AW-1:0]), .wdata(load_value),
    .raddr(g_raddr), .rdata(g_rd)
  );

  bgi_blend u_blend (.clk(clk), .rst(rst), .req(breq), .rsp(brsp));

  always_comb begin
    ax_rd = ax_sel ? y_rd : x_rd;
    qv    = ax_sel ? qy : qx;
    n_cur = ax_sel ? ny : nx;
    wx    = NUM_W'(x1) - NUM_W'(x0);
    wy    = NUM_W'(y1) - NUM_W'(y0);
    ny_g  = G_AW'(ny);
    im1_g = G_AW'(i - 1'b1);
    jm1_g = G_AW'(j - 1'b1);
    if (brsp.value > D_W'(32'sh7FFF_FFFF)) begin
      v_sat = 32'sh7FFF_FFFF;
    end else if (brsp.value < -D_W'(64'sh8000_0000)) begin
      v_sat = 32'sh8000_0000;
    end else begin
      v_sat = brsp.value[VAL_W-1:0];
    end
  end

  always_comb begin
    case (state)
      S_S1:    rd_addr = AX_AW'(n_cur - 1'b1);
      S_S2:    rd_addr = AX_AW'(1);
      S_S3:    rd_addr = k + 1'b1;
      S_E0:    rd_addr = cell_idx - 1'b1;
      S_E1:    rd_addr = cell_idx;
      default: rd_addr = '0;
    endcase
    case (state)
      S_G1:    g_raddr = gbase + 1'b1;
      S_G2:    g_raddr = gbase + ny_g;
      S_G3:    g_raddr = gbase + ny_g + 1'b1;
      default: g_raddr = gbase;
    endcase
  end

  always_comb begin
    breq.start = (state == S_B1) || (state == S_B2) || (state == S_B3);
    case (state)
      S_B2: begin
        breq.base = D_W'(c2);
        breq.d    = D_W'(c3) - D_W'(c2);
        breq.num  = NUM_W'(qy) - NUM_W'(y0);
        breq.den  = wy;
      end
      S_B3: begin
        breq.base = a_val;
        breq.d    = b_val - a_val;
        breq.num  = NUM_W'(qx) - NUM_W'(x0);
        breq.den  = wx;
      end
      default: begin
        breq.base = D_W'(c1);
        breq.d    = D_W'(c4) - D_W'(c1);
        breq.num  = NUM_W'(qy) - NUM_W'(y0);
        breq.den  = wy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && command == CMD_QUERY) state_next = S_S0;
      S_S0:   state_next = S_S1;
      S_S1:   state_next = S_S2;
      S_S2: begin
        if (qv < lo_bp || qv >= ax_rd || n_cur == AXN_W'(2)) begin
          state_next = S_E0;
        end else begin
          state_next = S_S3;
        end
      end
      S_S3: begin
        if (ax_rd > qv || AXN_W'(k) == n_cur - AXN_W'(2)) state_next = S_E0;
      end
      S_E0:   state_next = S_E1;
      S_E1:   state_next = S_E2;
      S_E2:   state_next = ax_sel ? S_CHK : S_S0;
      S_CHK:  state_next = (wx == '0 || wy == '0) ? S_OUT : S_G0;
      S_G0:   state_next = S_G1;
      S_G1:   state_next = S_G2;
      S_G2:   state_next = S_G3;
      S_G3:   state_next = S_G4;
      S_G4:   state_next = S_B1;
      S_B1:   state_next = S_W1;
      S_W1:   if (brsp.done) state_next = S_B2;
      S_B2:   state_next = S_W2;
      S_W2:   if (brsp.done) state_next = S_B3;
      S_B3:   state_next = S_W3;
      S_W3:   if (brsp.done) state_next = S_OUT;
      S_OUT:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qx     <= query_x;
        qy     <= query_y;
        nx     <= eff_count(x_count, X_MAX);
        ny     <= eff_count(y_count, Y_MAX);
        ax_sel <= 1'b0;
      end
      S_S1: lo_bp <= ax_rd;
      S_S2: begin
        k <= AX_AW'(1);
        if (qv < lo_bp) begin
          cell_idx <= AX_AW'(1);
        end else if (qv >= ax_rd) begin
          cell_idx <= AX_AW'(n_cur - 1'b1);
        end else begin
          cell_idx <= AX_AW'(1);
        end
      end
      S_S3: begin
        if (ax_rd > qv) begin
          cell_idx <= k;
        end else begin
          cell_idx <= AX_AW'(n_cur - 1'b1);
        end
        k <= k + 1'b1;
      end
      S_E1: lo_v <= ax_rd;
      S_E2: begin
        if (ax_sel) begin
          y0 <= lo_v;
          y1 <= ax_rd;
          j  <= cell_idx;
        end else begin
          x0 <= lo_v;
          x1 <= ax_rd;
          i  <= cell_idx;
        end
        ax_sel <= 1'b1;
      end
      S_CHK: begin
        gbase   <= ny_g * im1_g + jm1_g;
        out_val <= '0;
        out_st  <= ST_ZERO_WIDTH;
      end
      S_G1: c1 <= g_rd;
      S_G2: c4 <= g_rd;
      S_G3: c2 <= g_rd;
      S_G4: c3 <= g_rd;
      S_W1: if (brsp.done) a_val <= brsp.value;
      S_W2: if (brsp.done) b_val <= brsp.value;
      S_W3: begin
        if (brsp.done) begin
          out_val <= v_sat;
          out_st  <= v_sat[VAL_W-1] ? ST_NEG : ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.valid  = (state == S_OUT);
  assign res.value  = out_val;
  assign res.status = out_st;

endmodule
`default_nettype wire

[rtl/core/bilinear_grid_interpolation_top.sv]
// Top level: APB register port, output word register, query sequencer.
// Depends on bgi_pkg and bgi_seq.
`default_nettype none
// Loads (x breakpoint, y breakpoint, grid value) are taken one per cycle while
// idle and give no output word. A query holds the input stalled until its word
// moves to the output register: a linear cell search on each axis through the
// registered axis memories, a width check, the corner reads and the three
// blend steps of the shared serial unit (shift-add multiply over 33 bits,
// restoring division over 96 bits). A query that hits a zero-width cell skips
// the corner reads and the blend. Memories are not cleared at reset; entries
// read before being loaded return arbitrary data.
module bilinear_grid_interpolation_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [11:0] slot,
  input  wire logic signed [31:0] load_value,
  input  wire logic signed [31:0] query_x,
  input  wire logic signed [31:0] query_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] interpolated,
  output logic      [1:0]  status
);
  import bgi_pkg::*;

  logic [CNT_W-1:0] x_count, y_count;
  logic             wr;
  logic             res_ready;
  result_t          res;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? 32'(y_count) : 32'(x_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= CNT_W'(2);
      y_count <= CNT_W'(2);
    end else if (wr) begin
      if (paddr[2]) begin
        y_count <= pwdata[CNT_W-1:0];
      end else begin
        x_count <= pwdata[CNT_W-1:0];
      end
    end
  end

  bgi_seq u_seq (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(cmd_t'(command)), .slot(slot), .load_value(load_value),
    .query_x(query_x), .query_y(query_y),
    .x_count(x_count), .y_count(y_count),
    .res(res), .res_ready(res_ready)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      interpolated <= res.value;
      status       <= res.status;
    end
  end

  a_zero_width_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ZERO_WIDTH) |-> (interpolated == '0))
    else $error("zero-width word carries nonzero value");

  a_sign_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_OK || status == ST_NEG)) |->
      (interpolated[31] == (status == ST_NEG)))
    else $error("status does not match result sign");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == CMD_QUERY) |=> in_stall)
    else $error("input taken while query in flight");

endmodule
`default_nettype wire
